[hw/rtl/nearest_neighbor_pixel_scaler_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the nearest-neighbor pixel scaler
// Concurrent checks sampled on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef NEAREST_NEIGHBOR_PIXEL_SCALER_TOP_MACROS_SVH
`define NEAREST_NEIGHBOR_PIXEL_SCALER_TOP_MACROS_SVH

// Same-cycle implication
`define NNPS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nnps assertion failed");

// Next-cycle implication
`define NNPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nnps assertion failed");

`endif

[hw/rtl/nnps_pkg.sv]
// ----------------------------------------------------------------------------
// nnps_pkg
// Shared constants, types and helper functions of the pixel scaler.
// ----------------------------------------------------------------------------
package nnps_pkg;

    localparam int MAX_DIM    = 4096;
    localparam int MAX_REPEAT = 8;

    localparam int DIM_W   = 13;
    localparam int COORD_W = 12;
    localparam int PIX_W   = 32;
    localparam int REP_W   = (MAX_REPEAT > 1) ? $clog2(MAX_REPEAT) : 1;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam int DIV_STEPS = DIM_W;
    localparam int DIV_CW    = $clog2(DIV_STEPS + 1);

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // Register reset values
    localparam int SRC_W_RESET = 1;
    localparam int SRC_H_RESET = 1;
    localparam int DST_W_RESET = 640;
    localparam int DST_H_RESET = 480;

    localparam int QX_RESET = DST_W_RESET / SRC_W_RESET;
    localparam int RX_RESET = DST_W_RESET % SRC_W_RESET;
    localparam int QY_RESET = DST_H_RESET / SRC_H_RESET;
    localparam int RY_RESET = DST_H_RESET % SRC_H_RESET;

    typedef enum logic [1:0] {
        REG_SRC_WIDTH  = 2'd0,
        REG_SRC_HEIGHT = 2'd1,
        REG_DST_WIDTH  = 2'd2,
        REG_DST_HEIGHT = 2'd3
    } reg_idx_t;

    // One queued source pixel with its destination bases
    typedef struct packed {
        logic [COORD_W-1:0] col_base;
        logic [COORD_W-1:0] row_base;
        logic [PIX_W-1:0]   pixel;
    } item_t;

    // Repeat counts minus one, per axis
    typedef struct packed {
        logic [REP_W-1:0] rx_m1;
        logic [REP_W-1:0] ry_m1;
    } rep_t;

    // Quotient and remainder of one ratio
    typedef struct packed {
        logic [DIM_W-1:0]   quo;
        logic [COORD_W-1:0] rem;
    } div_res_t;

    // Saturate a dimension to 1 .. MAX_DIM
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0)
            r = DIM_W'(1);
        else if (int'(v) > MAX_DIM)
            r = DIM_W'(MAX_DIM);
        return r;
    endfunction

    // ceil(dst/src) clamped to 1 .. MAX_REPEAT, returned minus one
    function automatic logic [REP_W-1:0] rep_m1_of(input logic [DIM_W-1:0] q,
                                                   input logic [COORD_W-1:0] r);
        logic [DIM_W:0]   n;
        logic [REP_W-1:0] m;
        n = {1'b0, q} + (DIM_W+1)'(r != '0);
        if (n > (DIM_W+1)'(MAX_REPEAT))
            m = REP_W'(MAX_REPEAT - 1);
        else if (n == '0)
            m = '0;
        else
            m = REP_W'(n - 1'b1);
        return m;
    endfunction

endpackage

[hw/rtl/nearest_neighbor_pixel_scaler_top.sv]
// ----------------------------------------------------------------------------
// nearest_neighbor_pixel_scaler_top
// Throughput: one destination write per cycle while out_ready is high; a
//   source pixel makes rx*ry writes (rx, ry = ceil(dst/src) per axis, at most
//   8). A new pixel is taken every cycle while the 4-entry queue has room and
//   no ratio update runs; it passes the queue, current and output registers.
//   A register write holds in_ready low for start, 13 divide steps and ratio
//   load. Reset loads the default registers and their ratios at once.
// ----------------------------------------------------------------------------
module nearest_neighbor_pixel_scaler_top
    import nnps_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready,
    // source pixels
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [PIX_W-1:0]   pixel_in,
    // destination writes
    output logic               out_valid,
    input  logic               out_ready,
    output logic [COORD_W-1:0] dst_x,
    output logic [COORD_W-1:0] dst_y,
    output logic [PIX_W-1:0]   pixel_out,
    output logic               last
);

    // Configuration registers
    logic [DIM_W-1:0] src_w_reg, src_w_next;
    logic [DIM_W-1:0] src_h_reg, src_h_next;
    logic [DIM_W-1:0] dst_w_reg, dst_w_next;
    logic [DIM_W-1:0] dst_h_reg, dst_h_next;
    logic             start_reg, start_next;

    logic             cfg_wr;
    reg_idx_t         cfg_idx;

    logic [DIM_W-1:0] sw, sh, dw, dh;
    logic             busy_x, busy_y, done_x, done_y, busy;
    div_res_t         res_x, res_y;

    logic             push, pop, fifo_full, fifo_empty;
    item_t            push_item, head;
    rep_t             rep;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[APB_AW-1:2]);

    // Register write decode; a transaction also restarts the frame and
    // kicks off the ratio division on the following cycle
    always_comb
    begin
        src_w_next = src_w_reg;
        src_h_next = src_h_reg;
        dst_w_next = dst_w_reg;
        dst_h_next = dst_h_reg;
        start_next = cfg_wr;
        if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_SRC_WIDTH:  src_w_next = pwdata[DIM_W-1:0];
                REG_SRC_HEIGHT: src_h_next = pwdata[DIM_W-1:0];
                REG_DST_WIDTH:  dst_w_next = pwdata[DIM_W-1:0];
                REG_DST_HEIGHT: dst_h_next = pwdata[DIM_W-1:0];
                default:        src_w_next = src_w_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg <= DIM_W'(SRC_W_RESET);
            src_h_reg <= DIM_W'(SRC_H_RESET);
            dst_w_reg <= DIM_W'(DST_W_RESET);
            dst_h_reg <= DIM_W'(DST_H_RESET);
            start_reg <= 1'b0;
        end
        else
        begin
            src_w_reg <= src_w_next;
            src_h_reg <= src_h_next;
            dst_w_reg <= dst_w_next;
            dst_h_reg <= dst_h_next;
            start_reg <= start_next;
        end
    end

    // Read back the stored register value
    always_comb
    begin
        unique case (cfg_idx)
            REG_SRC_WIDTH:  prdata = APB_DW'(src_w_reg);
            REG_SRC_HEIGHT: prdata = APB_DW'(src_h_reg);
            REG_DST_WIDTH:  prdata = APB_DW'(dst_w_reg);
            REG_DST_HEIGHT: prdata = APB_DW'(dst_h_reg);
            default:        prdata = '0;
        endcase
    end

    // Dimensions as used by the datapath: zero acts as one, large values clamp
    assign sw = eff_dim(src_w_reg);
    assign sh = eff_dim(src_h_reg);
    assign dw = eff_dim(dst_w_reg);
    assign dh = eff_dim(dst_h_reg);

    // Hold off new pixels until the ratio terms are loaded into the front
    assign busy = start_reg || busy_x || busy_y || done_x || done_y;

    nnps_div u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start_reg),
        .dividend (dw),
        .divisor  (sw),
        .busy     (busy_x),
        .done     (done_x),
        .result   (res_x)
    );

    nnps_div u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start_reg),
        .dividend (dh),
        .divisor  (sh),
        .busy     (busy_y),
        .done     (done_y),
        .result   (res_y)
    );

    // Front: accept pixels and attach their destination bases
    nnps_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_clear  (cfg_wr),
        .busy       (busy),
        .sw         (sw),
        .sh         (sh),
        .div_x_done (done_x),
        .div_x      (res_x),
        .div_y_done (done_y),
        .div_y      (res_y),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .pixel_in   (pixel_in),
        .fifo_full  (fifo_full),
        .push       (push),
        .push_item  (push_item),
        .rep        (rep)
    );

    // Queue decouples pixel intake from write expansion
    nnps_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_item (push_item),
        .pop     (pop),
        .rd_item (head),
        .full    (fifo_full),
        .empty   (fifo_empty)
    );

    // Back: step x inside y and drive the registered output
    nnps_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .rep        (rep),
        .fifo_empty (fifo_empty),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .dst_x      (dst_x),
        .dst_y      (dst_y),
        .pixel_out  (pixel_out),
        .last       (last)
    );

endmodule

[hw/rtl/nnps_div.sv]
// ----------------------------------------------------------------------------
// nnps_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module nnps_div
    import nnps_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIM_W-1:0] dividend,
    input  logic [DIM_W-1:0] divisor,
    output logic             busy,
    output logic             done,
    output div_res_t         result
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIV_CW-1:0] cnt_reg, cnt_next;
    logic [DIM_W-1:0]  quo_reg, quo_next;
    logic [DIM_W-1:0]  rem_reg, rem_next;
    logic [DIM_W-1:0]  dsr_reg, dsr_next;

    logic [DIM_W:0]    rem_sh;
    logic              ge;

    always_comb
    begin
        rem_sh    = {rem_reg, quo_reg[DIM_W-1]};
        ge        = rem_sh >= {1'b0, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CW'(DIV_STEPS);
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DIM_W-2:0], ge};
            rem_next = ge ? DIM_W'(rem_sh - {1'b0, dsr_reg}) : DIM_W'(rem_sh);
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign busy       = busy_reg;
    assign done       = done_reg;
    assign result.quo = quo_reg;
    assign result.rem = rem_reg[COORD_W-1:0];

endmodule

[hw/rtl/nnps_front.sv]
// ----------------------------------------------------------------------------
// nnps_front
// Accept source pixels, track raster position and destination bases.
// ----------------------------------------------------------------------------
module nnps_front
    import nnps_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_clear,
    input  logic             busy,
    input  logic [DIM_W-1:0] sw,
    input  logic [DIM_W-1:0] sh,
    input  logic             div_x_done,
    input  div_res_t         div_x,
    input  logic             div_y_done,
    input  div_res_t         div_y,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [PIX_W-1:0] pixel_in,
    input  logic             fifo_full,
    output logic             push,
    output item_t            push_item,
    output rep_t             rep
);

    logic [COORD_W-1:0] src_col_reg, src_col_next;
    logic [COORD_W-1:0] src_row_reg, src_row_next;
    logic [COORD_W-1:0] col_base_reg, col_base_next;
    logic [COORD_W-1:0] col_rem_reg, col_rem_next;
    logic [COORD_W-1:0] row_base_reg, row_base_next;
    logic [COORD_W-1:0] row_rem_reg, row_rem_next;
    logic [DIM_W-1:0]   qx_reg, qy_reg;
    logic [COORD_W-1:0] rx_reg, ry_reg;
    rep_t               rep_reg;

    logic               accept;
    logic [DIM_W-1:0]   col_inc, row_inc;
    logic [DIM_W-1:0]   col_rem_sum, row_rem_sum;
    logic               col_wrap, row_wrap;

    assign in_ready = !busy && !fifo_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        col_inc     = {1'b0, src_col_reg} + 1'b1;
        row_inc     = {1'b0, src_row_reg} + 1'b1;
        col_rem_sum = {1'b0, col_rem_reg} + {1'b0, rx_reg};
        row_rem_sum = {1'b0, row_rem_reg} + {1'b0, ry_reg};
        col_wrap    = col_rem_sum >= sw;
        row_wrap    = row_rem_sum >= sh;

        src_col_next  = src_col_reg;
        src_row_next  = src_row_reg;
        col_base_next = col_base_reg;
        col_rem_next  = col_rem_reg;
        row_base_next = row_base_reg;
        row_rem_next  = row_rem_reg;

        if (cfg_clear)
        begin
            src_col_next  = '0;
            src_row_next  = '0;
            col_base_next = '0;
            col_rem_next  = '0;
            row_base_next = '0;
            row_rem_next  = '0;
        end
        else if (accept)
        begin
            if (col_inc >= sw)
            begin
                // end of row: restart columns, step rows
                src_col_next  = '0;
                col_base_next = '0;
                col_rem_next  = '0;
                if (row_inc >= sh)
                begin
                    src_row_next  = '0;
                    row_base_next = '0;
                    row_rem_next  = '0;
                end
                else
                begin
                    src_row_next  = row_inc[COORD_W-1:0];
                    row_base_next = row_base_reg + qy_reg[COORD_W-1:0]
                                    + COORD_W'(row_wrap);
                    row_rem_next  = row_wrap ? COORD_W'(row_rem_sum - sh)
                                             : row_rem_sum[COORD_W-1:0];
                end
            end
            else
            begin
                src_col_next  = col_inc[COORD_W-1:0];
                col_base_next = col_base_reg + qx_reg[COORD_W-1:0] + COORD_W'(col_wrap);
                col_rem_next  = col_wrap ? COORD_W'(col_rem_sum - sw)
                                         : col_rem_sum[COORD_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_col_reg  <= '0;
            src_row_reg  <= '0;
            col_base_reg <= '0;
            col_rem_reg  <= '0;
            row_base_reg <= '0;
            row_rem_reg  <= '0;
        end
        else
        begin
            src_col_reg  <= src_col_next;
            src_row_reg  <= src_row_next;
            col_base_reg <= col_base_next;
            col_rem_reg  <= col_rem_next;
            row_base_reg <= row_base_next;
            row_rem_reg  <= row_rem_next;
        end
    end

    // Ratio terms and repeat counts, refreshed when a division finishes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qx_reg        <= DIM_W'(QX_RESET);
            rx_reg        <= COORD_W'(RX_RESET);
            qy_reg        <= DIM_W'(QY_RESET);
            ry_reg        <= COORD_W'(RY_RESET);
            rep_reg.rx_m1 <= rep_m1_of(DIM_W'(QX_RESET), COORD_W'(RX_RESET));
            rep_reg.ry_m1 <= rep_m1_of(DIM_W'(QY_RESET), COORD_W'(RY_RESET));
        end
        else
        begin
            if (div_x_done)
            begin
                qx_reg        <= div_x.quo;
                rx_reg        <= div_x.rem;
                rep_reg.rx_m1 <= rep_m1_of(div_x.quo, div_x.rem);
            end
            if (div_y_done)
            begin
                qy_reg        <= div_y.quo;
                ry_reg        <= div_y.rem;
                rep_reg.ry_m1 <= rep_m1_of(div_y.quo, div_y.rem);
            end
        end
    end

    assign push               = accept;
    assign push_item.col_base = col_base_reg;
    assign push_item.row_base = row_base_reg;
    assign push_item.pixel    = pixel_in;
    assign rep                = rep_reg;

endmodule

[hw/rtl/nnps_fifo.sv]
// ----------------------------------------------------------------------------
// nnps_fifo
// Short register queue between the front and back parts.
// ----------------------------------------------------------------------------
module nnps_fifo
    import nnps_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t wr_item,
    input  logic  pop,
    output item_t rd_item,
    output logic  full,
    output logic  empty
);

    item_t              entries[FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CW-1:0] count_reg, count_next;
    logic               do_push, do_pop;

    assign full    = count_reg == FIFO_CW'(FIFO_DEPTH);
    assign empty   = count_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entries[wr_ptr_reg] <= wr_item;
    end

    assign rd_item = entries[rd_ptr_reg];

endmodule

[hw/rtl/nnps_back.sv]
// ----------------------------------------------------------------------------
// nnps_back
// Expand each queued pixel into its block of replicated writes.
// ----------------------------------------------------------------------------
module nnps_back
    import nnps_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  rep_t               rep,
    input  logic               fifo_empty,
    input  item_t              head,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [COORD_W-1:0] dst_x,
    output logic [COORD_W-1:0] dst_y,
    output logic [PIX_W-1:0]   pixel_out,
    output logic               last
);

    logic               cur_valid_reg, cur_valid_next;
    item_t              cur_reg;
    logic [REP_W-1:0]   ox_reg, ox_next;
    logic [REP_W-1:0]   oy_reg, oy_next;
    logic               out_valid_reg, out_valid_next;
    logic [COORD_W-1:0] dst_x_reg, dst_y_reg;
    logic [PIX_W-1:0]   pix_reg;
    logic               last_reg;

    logic load_out, emit, x_end, y_end, is_last, take;

    always_comb
    begin
        load_out = !out_valid_reg || out_ready;
        emit     = load_out && cur_valid_reg;
        x_end    = ox_reg == rep.rx_m1;
        y_end    = oy_reg == rep.ry_m1;
        is_last  = x_end && y_end;
        take     = !cur_valid_reg || (emit && is_last);
        pop      = take && !fifo_empty;

        cur_valid_next = take ? !fifo_empty : cur_valid_reg;
        out_valid_next = load_out ? cur_valid_reg : out_valid_reg;

        ox_next = ox_reg;
        oy_next = oy_reg;
        if (take)
        begin
            ox_next = '0;
            oy_next = '0;
        end
        else if (emit)
        begin
            if (x_end)
            begin
                ox_next = '0;
                oy_next = oy_reg + 1'b1;
            end
            else
                ox_next = ox_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            ox_reg        <= '0;
            oy_reg        <= '0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
            ox_reg        <= ox_next;
            oy_reg        <= oy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            cur_reg <= head;
        if (emit)
        begin
            dst_x_reg <= cur_reg.col_base + COORD_W'(ox_reg);
            dst_y_reg <= cur_reg.row_base + COORD_W'(oy_reg);
            pix_reg   <= cur_reg.pixel;
            last_reg  <= is_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign dst_x     = dst_x_reg;
    assign dst_y     = dst_y_reg;
    assign pixel_out = pix_reg;
    assign last      = last_reg;

endmodule

[hw/rtl/nnps_checker.sv]
// ----------------------------------------------------------------------------
// nnps_checker
// Port-level checks on the pixel scaler, bound to the top level.
// ----------------------------------------------------------------------------
`include "nearest_neighbor_pixel_scaler_top_macros.svh"

module nnps_checker
    import nnps_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               psel,
    input logic               penable,
    input logic               pwrite,
    input logic               pready,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [COORD_W-1:0] dst_x,
    input logic [COORD_W-1:0] dst_y,
    input logic [PIX_W-1:0]   pixel_out,
    input logic               last
);

    // Stalled write holds its payload
    `NNPS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(dst_x) && $stable(dst_y) && $stable(pixel_out) && $stable(last))

    // Register write blocks intake while ratios are recomputed
    `NNPS_ASSERT_NEXT(a_cfg_blocks_in, psel && penable && pwrite && pready, !in_ready)

    // Writes of one pixel follow without a gap and carry the same value
    `NNPS_ASSERT_NEXT(a_burst_pixel, out_valid && out_ready && !last,
        out_valid && (pixel_out == $past(pixel_out)))

    // Consecutive writes of one pixel move to a new location
    `NNPS_ASSERT_NEXT(a_burst_moves, out_valid && out_ready && !last,
        (dst_x != $past(dst_x)) || (dst_y != $past(dst_y)))

endmodule

bind nearest_neighbor_pixel_scaler_top nnps_checker u_nnps_checker (.*);

[tb/sv/tb_nearest_neighbor_pixel_scaler_top.sv]
// ============================================================================
// Testbench for nearest_neighbor_pixel_scaler_top
// Streams source pixels through the scaler under several image geometries,
// predicts every replicated destination write in-line and checks each write
// field by field, with random gaps on the source side and random back-pressure
// on the destination side.
// ============================================================================
module tb_nearest_neighbor_pixel_scaler_top;
    import nnps_pkg::*;

    localparam int unsigned ITEM_TARGET = 460;  // stop generating phases here
    localparam int unsigned CALM_FROM   = 400;  // no gaps or stalls after this
    localparam int unsigned QUIET_LIMIT = 4000; // cycles without any transaction
    localparam int unsigned SETTLE      = 4;    // cycles after the last write
    localparam int unsigned TAIL_CYCLES = 16;
    localparam int unsigned COORD_MASK  = (1 << COORD_W) - 1;

    // One destination write as the scaler should emit it
    typedef struct {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [PIX_W-1:0]   pixel;
        logic               last;
    } dst_write_t;

    logic               clk;
    logic               rst_n     = 1'b0;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [APB_AW-1:0]  paddr     = '0;
    logic [APB_DW-1:0]  pwdata    = '0;
    logic [APB_DW-1:0]  prdata;
    logic               pready;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    logic [PIX_W-1:0]   pixel_in  = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [COORD_W-1:0] dst_x;
    logic [COORD_W-1:0] dst_y;
    logic [PIX_W-1:0]   pixel_out;
    logic               last;

    nearest_neighbor_pixel_scaler_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .pixel_in  (pixel_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .dst_x     (dst_x),
        .dst_y     (dst_y),
        .pixel_out (pixel_out),
        .last      (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Scaling predictor: own copy of the registers, the ratio terms and the
    // raster counters. Updated by the monitor at the edge of each transaction.
    // ------------------------------------------------------------------------
    logic [DIM_W-1:0] settings [4];
    int unsigned quo_x, rem_x, quo_y, rem_y;
    int unsigned col_idx, row_idx, col_base, col_acc, row_base, row_acc;
    dst_write_t  expected_writes [$];

    // Out-of-range dimensions behave as if clamped to 1 .. MAX_DIM
    function automatic int unsigned clamp_dim(logic [DIM_W-1:0] v);
        if (v == '0)
            return 1;
        if (int'(v) > MAX_DIM)
            return MAX_DIM;
        return int'(v);
    endfunction

    // ceil(dst/src) from quotient and remainder, held to 1 .. MAX_REPEAT
    function automatic int unsigned repeat_count(int unsigned q, int unsigned r);
        int unsigned n;
        n = q + ((r != 0) ? 1 : 0);
        if (n > MAX_REPEAT)
            n = MAX_REPEAT;
        if (n < 1)
            n = 1;
        return n;
    endfunction

    // Recompute the ratios and start a fresh frame
    function automatic void restart_frame();
        int unsigned sw, sh, dw, dh;
        sw = clamp_dim(settings[REG_SRC_WIDTH]);
        sh = clamp_dim(settings[REG_SRC_HEIGHT]);
        dw = clamp_dim(settings[REG_DST_WIDTH]);
        dh = clamp_dim(settings[REG_DST_HEIGHT]);
        quo_x    = dw / sw;
        rem_x    = dw % sw;
        quo_y    = dh / sh;
        rem_y    = dh % sh;
        col_idx  = 0;
        row_idx  = 0;
        col_base = 0;
        col_acc  = 0;
        row_base = 0;
        row_acc  = 0;
    endfunction

    // Queue the block of writes for one source pixel, then advance the raster
    function automatic void scale_pixel(logic [PIX_W-1:0] pix);
        int unsigned sw, sh, rep_x, rep_y;
        dst_write_t  w;
        sw    = clamp_dim(settings[REG_SRC_WIDTH]);
        sh    = clamp_dim(settings[REG_SRC_HEIGHT]);
        rep_x = repeat_count(quo_x, rem_x);
        rep_y = repeat_count(quo_y, rem_y);
        for (int unsigned oy = 0; oy < rep_y; oy++)
        begin
            for (int unsigned ox = 0; ox < rep_x; ox++)
            begin
                w.x     = COORD_W'((col_base + ox) & COORD_MASK);
                w.y     = COORD_W'((row_base + oy) & COORD_MASK);
                w.pixel = pix;
                w.last  = (oy + 1 == rep_y) && (ox + 1 == rep_x);
                expected_writes.push_back(w);
            end
        end
        col_idx++;
        if (col_idx >= sw)
        begin
            // end of row: rewind the columns, step the row accumulators
            col_idx  = 0;
            col_base = 0;
            col_acc  = 0;
            row_idx++;
            if (row_idx >= sh)
            begin
                // end of frame: everything back to the origin
                row_idx  = 0;
                row_base = 0;
                row_acc  = 0;
            end
            else
            begin
                row_base += quo_y;
                row_acc  += rem_y;
                if (row_acc >= sh)
                begin
                    row_acc -= sh;
                    row_base++;
                end
                row_base &= COORD_MASK;
            end
        end
        else
        begin
            col_base += quo_x;
            col_acc  += rem_x;
            if (col_acc >= sw)
            begin
                col_acc -= sw;
                col_base++;
            end
            col_base &= COORD_MASK;
        end
        col_idx &= COORD_MASK;
        row_idx &= COORD_MASK;
    endfunction

    // ------------------------------------------------------------------------
    // Shared bookkeeping between stimulus, driver and monitor
    // ------------------------------------------------------------------------
    logic [PIX_W-1:0] pending_pixels [$];
    int unsigned n_sent       = 0;
    int unsigned n_accepted   = 0;
    int unsigned n_writes     = 0;
    int unsigned n_reg_writes = 0;
    int unsigned n_settings   = 0;
    int unsigned mismatches   = 0;
    int unsigned quiet_cycles = 0;
    int unsigned gap_pct      = 0;
    int unsigned stall_pct    = 0;
    int unsigned gap_left     = 0;
    int unsigned stall_left   = 0;
    bit          calm         = 1'b0;

    function automatic void check_field(string name, logic [PIX_W-1:0] want,
                                        logic [PIX_W-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Driver: source pixels from the pending queue, and destination ready.
    // Each side goes quiet in bursts of random length unless the run is calm.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            out_ready <= 1'b0;
        end
        else
        begin
            // hold valid and payload until the current transaction is taken
            if (!in_valid || in_ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_pixels.size() == 0)
                    in_valid <= 1'b0;
                else if (!calm && $urandom_range(0, 99) < gap_pct)
                begin
                    gap_left = $urandom_range(0, 13);
                    in_valid <= 1'b0;
                end
                else
                begin
                    in_valid <= 1'b1;
                    pixel_in <= pending_pixels.pop_front();
                end
            end

            // back-pressure on the write side
            if (stall_left != 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 99) < stall_pct)
            begin
                stall_left = $urandom_range(0, 13);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: apply register writes and accepted pixels to the predictor,
    // check every accepted write against the oldest expectation, and end the
    // run if nothing moves for too long.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        bit         progress;
        dst_write_t want;
        if (rst_n)
        begin
            progress = 1'b0;
            if (psel && penable && pwrite && pready)
            begin
                settings[reg_idx_t'(paddr[3:2])] = pwdata[DIM_W-1:0];
                restart_frame();
                n_reg_writes++;
                progress = 1'b1;
            end
            if (in_valid && in_ready)
            begin
                scale_pixel(pixel_in);
                n_accepted++;
                progress = 1'b1;
            end
            if (out_valid && out_ready)
            begin
                progress = 1'b1;
                n_writes++;
                if (expected_writes.size() == 0)
                begin
                    $error("unexpected write: x=%0d y=%0d pixel=0x%0h last=%0b",
                           dst_x, dst_y, pixel_out, last);
                    mismatches++;
                end
                else
                begin
                    want = expected_writes.pop_front();
                    check_field("dst_x", PIX_W'(want.x), PIX_W'(dst_x));
                    check_field("dst_y", PIX_W'(want.y), PIX_W'(dst_y));
                    check_field("pixel_out", want.pixel, pixel_out);
                    check_field("last", PIX_W'(want.last), PIX_W'(last));
                end
            end
            quiet_cycles = progress ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $error("no transaction for %0d cycles", QUIET_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    logic [DIM_W-1:0] plan [4];  // register values as last written

    // Setup cycle, then access cycle; the register lands at the access edge
    task automatic write_register(reg_idx_t idx, logic [APB_DW-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(4 * int'(idx));
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        plan[idx] = value[DIM_W-1:0];
    endtask

    task automatic load_geometry(logic [APB_DW-1:0] sw, logic [APB_DW-1:0] sh,
                                 logic [APB_DW-1:0] dw, logic [APB_DW-1:0] dh);
        write_register(REG_SRC_WIDTH, sw);
        write_register(REG_SRC_HEIGHT, sh);
        write_register(REG_DST_WIDTH, dw);
        write_register(REG_DST_HEIGHT, dh);
        n_settings++;
    endtask

    task automatic queue_pixel(logic [PIX_W-1:0] pix);
        pending_pixels.push_back(pix);
        n_sent++;
    endtask

    // Wait until every pixel is taken and every write has come out, then
    // leave a few cycles so the block is truly idle before a register write.
    task automatic wait_drained();
        @(posedge clk);
        while (n_accepted != n_sent || expected_writes.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Mostly small geometries so frames complete; now and then the extremes
    function automatic logic [APB_DW-1:0] pick_dim(bit dst_side);
        int unsigned      r;
        logic [APB_DW-1:0] v;
        r = $urandom_range(0, 99);
        if (r < 70)
            v = dst_side ? $urandom_range(1, 40) : $urandom_range(1, 8);
        else if (r < 82)
            v = $urandom_range(9, 200);
        else
        begin
            case ($urandom_range(0, 4))
                0: v = 0;
                1: v = MAX_DIM;
                2: v = MAX_DIM + 1;
                3: v = (1 << DIM_W) - 1;
                default: v = $urandom_range(0, (1 << DIM_W) - 1);
            endcase
        end
        // stray upper bits must be dropped by the register
        if ($urandom_range(0, 7) == 0)
            v[APB_DW-1:DIM_W] = (APB_DW-DIM_W)'($urandom);
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus: directed geometries first, then random phases
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int unsigned frame, count, first;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        settings[REG_SRC_WIDTH]  = DIM_W'(SRC_W_RESET);
        settings[REG_SRC_HEIGHT] = DIM_W'(SRC_H_RESET);
        settings[REG_DST_WIDTH]  = DIM_W'(DST_W_RESET);
        settings[REG_DST_HEIGHT] = DIM_W'(DST_H_RESET);
        plan = settings;
        restart_frame();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // reset geometry: 1x1 into 640x480, both axes clamp to 8 repeats
        gap_pct   = 25;
        stall_pct = 25;
        n_settings++;
        queue_pixel(32'h0000_0000);
        queue_pixel(32'hFFFF_FFFF);
        queue_pixel(32'hAAAA_AAAA);
        queue_pixel(32'h5555_5555);
        wait_drained();

        // odd upscale: 3x2 into 7x5, uneven bases; run past one frame and
        // stop mid-frame so the next write restarts it
        load_geometry(3, 2, 7, 5);
        for (int i = 0; i < 8; i++)
            queue_pixel($urandom);
        wait_drained();

        // shrink: 5x3 into 2x1, one write per pixel, shared locations
        gap_pct   = 0;
        stall_pct = 40;
        load_geometry(5, 3, 2, 1);
        for (int i = 0; i < 6; i++)
            queue_pixel($urandom);
        wait_drained();

        // zero and oversized registers, garbage in the upper data bits
        gap_pct   = 40;
        stall_pct = 0;
        load_geometry(0, 32'h0000_1FFF, 32'hFFFF_FFFF, 0);
        for (int i = 0; i < 4; i++)
            queue_pixel($urandom);
        wait_drained();

        // random phases: retune at least one register, then mostly whole
        // frames with random content, sometimes a partial tail
        while (n_sent < ITEM_TARGET)
        begin
            calm = (n_sent >= CALM_FROM);
            case ($urandom_range(0, 3))
                0: gap_pct = 0;
                1: gap_pct = 8;
                2: gap_pct = 25;
                default: gap_pct = 45;
            endcase
            case ($urandom_range(0, 3))
                0: stall_pct = 0;
                1: stall_pct = 8;
                2: stall_pct = 25;
                default: stall_pct = 45;
            endcase
            first = $urandom_range(0, 3);
            for (int i = 0; i < 4; i++)
            begin
                if (i == first || $urandom_range(0, 1) == 1)
                    write_register(reg_idx_t'(i), pick_dim(i >= 2));
            end
            n_settings++;
            frame = clamp_dim(plan[REG_SRC_WIDTH]) * clamp_dim(plan[REG_SRC_HEIGHT]);
            if (frame <= 48 && $urandom_range(0, 9) < 8)
            begin
                count = frame * $urandom_range(1, 3);
                if ($urandom_range(0, 3) == 0)
                    count += $urandom_range(0, frame - 1);
            end
            else
                count = $urandom_range(4, 24);
            // keep the total close to the planned item count
            if (n_sent + count > ITEM_TARGET)
                count = ITEM_TARGET - n_sent;
            for (int unsigned i = 0; i < count; i++)
                queue_pixel($urandom);
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_writes.size() != 0)
        begin
            $error("%0d expected writes never arrived", expected_writes.size());
            mismatches++;
        end
        $display("Scaled %0d source pixels into %0d checked writes", n_accepted, n_writes);
        $display("under %0d geometries set by %0d register writes, %0d mismatches",
                 n_settings, n_reg_writes, mismatches);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
